// ===== rtl/yrc_pkg.sv =====
// ----------------------------------------------------------------------------
// yrc_pkg: shared types and constants of the YUYV to RGB888 converter
// Request layouts, chroma product bundle, lane control and Q16 coefficients.
// ----------------------------------------------------------------------------
package yrc_pkg;

  // Channel and field widths.
  localparam int CHAN_W  = 8;
  localparam int GAIN_W  = 9;
  localparam int FRAC_W  = 16;
  // Signed width of one chroma product (coefficient times chroma offset).
  localparam int PROD_W  = 26;
  // Signed width of one channel sum in Q16.
  localparam int SUM_W   = 28;
  // Width of the channel times gain product.
  localparam int SCALE_W = CHAN_W + GAIN_W;

  // Q16 color coefficients.
  localparam logic signed [PROD_W-1:0] COEF_RV = PROD_W'(89831);
  localparam logic signed [PROD_W-1:0] COEF_GV = PROD_W'(45744);
  localparam logic signed [PROD_W-1:0] COEF_GU = PROD_W'(22127);
  localparam logic signed [PROD_W-1:0] COEF_BU = PROD_W'(113538);

  localparam logic [CHAN_W-1:0] CHROMA_OFFSET = 8'd128;
  localparam logic [CHAN_W-1:0] CHAN_MAX      = 8'd255;
  localparam logic [GAIN_W-1:0] GAIN_RESET    = 9'd220;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_IDX_OUTPUT_GAIN = 1'b0;

  // One input request: a YUYV macropixel.
  typedef struct packed {
    logic [CHAN_W-1:0] first_luma;
    logic [CHAN_W-1:0] blue_chroma;
    logic [CHAN_W-1:0] second_luma;
    logic [CHAN_W-1:0] red_chroma;
  } in_t;

  // One result request: two RGB888 pixels.
  typedef struct packed {
    logic [CHAN_W-1:0] red_first;
    logic [CHAN_W-1:0] green_first;
    logic [CHAN_W-1:0] blue_first;
    logic [CHAN_W-1:0] red_second;
    logic [CHAN_W-1:0] green_second;
    logic [CHAN_W-1:0] blue_second;
  } out_t;

  // Chroma products shared by both lanes.
  typedef struct packed {
    logic signed [PROD_W-1:0] rv;
    logic signed [PROD_W-1:0] gv;
    logic signed [PROD_W-1:0] gu;
    logic signed [PROD_W-1:0] bu;
  } prod_t;

  // Load enables of the two lane stages.
  typedef struct packed {
    logic load_sum;
    logic load_scale;
  } lane_ctrl_t;

endpackage

// ===== rtl/yuyv_to_rgb888_converter_unit.sv =====
// ----------------------------------------------------------------------------
// yuyv_to_rgb888_converter_unit: YUYV macropixel to two RGB888 pixels
// Top level with request handshakes, gain register and the lane merge.
// ----------------------------------------------------------------------------
// Usage:
//   A request on the in_ channel carries one YUYV macropixel (Y0, U, Y1, V).
//   For each accepted request the out_ channel delivers exactly one request
//   holding two RGB888 pixels, in order. A request is taken at a rising edge
//   where valid is high and stall is low.
//   Between acceptance and out_valid, one stage forms the
//   shared chroma products, and two lanes (one per luma sample) clamp the
//   channels and then apply the gain into the output register.
//   Throughput is one macropixel per cycle while the receiver does not stall;
//   each stage holds one request and advances whenever the stage after it is
//   empty or moving on. When the receiver stalls, the output holds steady;
//   earlier stages keep filling until all three are occupied, and only then is in_stall raised.
//   The output_gain register sits at byte address 0 of the APB-style port and
//   resets to 220. It may be written only while no request is in flight.
//   Reset (rst_n low, synchronous) empties the pipeline and restores the gain.
// ----------------------------------------------------------------------------
module yuyv_to_rgb888_converter_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  yrc_pkg::in_t                      in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output yrc_pkg::out_t                     out_data,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [yrc_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [yrc_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [yrc_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);

  logic                          v1_r;
  logic                          v2_r;
  logic                          v3_r;
  logic                          ready1;
  logic                          ready2;
  logic                          ready3;
  logic                          load1;
  yrc_pkg::lane_ctrl_t           lane_ctrl;
  logic [yrc_pkg::GAIN_W-1:0]    gain_r;
  logic                          cfg_write;
  yrc_pkg::prod_t                prod;
  logic [yrc_pkg::CHAN_W-1:0]    y0;
  logic [yrc_pkg::CHAN_W-1:0]    y1;

  // Stage readiness: a stage loads when it is empty or its request moves on.
  assign ready3 = !v3_r || !out_stall;
  assign ready2 = !v2_r || ready3;
  assign ready1 = !v1_r || ready2;

  assign in_stall             = !ready1;
  assign load1                = ready1;
  assign lane_ctrl.load_sum   = ready2;
  assign lane_ctrl.load_scale = ready3;

  // Valid bits of the three stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (ready1) v1_r <= in_valid;
      if (ready2) v2_r <= v1_r;
      if (ready3) v3_r <= v2_r;
    end
  end

  // Configuration register.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready
                   && (paddr[2] == yrc_pkg::REG_IDX_OUTPUT_GAIN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= yrc_pkg::GAIN_RESET;
    end else if (cfg_write) begin
      gain_r <= pwdata[yrc_pkg::GAIN_W-1:0];
    end
  end

  assign prdata = (paddr[2] == yrc_pkg::REG_IDX_OUTPUT_GAIN)
                ? yrc_pkg::CFG_DATA_W'(gain_r) : '0;

  // Shared chroma stage.
  yrc_chroma u_chroma (
    .clk         (clk),
    .load        (load1),
    .in_data     (in_data),
    .prod        (prod),
    .first_luma  (y0),
    .second_luma (y1)
  );

  // One lane per luma sample; their final registers merge into the result.
  yrc_lane u_lane_first (
    .clk   (clk),
    .ctrl  (lane_ctrl),
    .luma  (y0),
    .prod  (prod),
    .gain  (gain_r),
    .red   (out_data.red_first),
    .green (out_data.green_first),
    .blue  (out_data.blue_first)
  );

  yrc_lane u_lane_second (
    .clk   (clk),
    .ctrl  (lane_ctrl),
    .luma  (y1),
    .prod  (prod),
    .gain  (gain_r),
    .red   (out_data.red_second),
    .green (out_data.green_second),
    .blue  (out_data.blue_second)
  );

  assign out_valid = v3_r;

`ifndef SYNTH
  // The input is only held off when every stage is occupied.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v1_r && v2_r && v3_r))
    else $error("input stalled with an empty stage");

  // An accepted request always occupies the first stage next cycle.
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> v1_r)
    else $error("accepted request was lost");

  // A clamp-stage request blocked by the output stays in place.
  a_stage2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !ready3) |=> v2_r)
    else $error("clamp stage dropped a blocked request");

  // A delivered result with nothing behind it leaves the output empty.
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && !out_stall && !v2_r) |=> !v3_r)
    else $error("result repeated after delivery");
`endif

endmodule

// ===== rtl/yrc_chroma.sv =====
// ----------------------------------------------------------------------------
// yrc_chroma: shared chroma product stage
// Removes the chroma offset and forms the four coefficient products once per
// macropixel; the two luma samples are registered alongside.
// ----------------------------------------------------------------------------
module yrc_chroma (
  input  logic                          clk,
  input  logic                          load,
  input  yrc_pkg::in_t                  in_data,
  output yrc_pkg::prod_t                prod,
  output logic [yrc_pkg::CHAN_W-1:0]    first_luma,
  output logic [yrc_pkg::CHAN_W-1:0]    second_luma
);

  logic signed [yrc_pkg::PROD_W-1:0] du;
  logic signed [yrc_pkg::PROD_W-1:0] dv;
  yrc_pkg::prod_t                    prod_r;
  yrc_pkg::prod_t                    prod_nxt;
  logic [yrc_pkg::CHAN_W-1:0]        y0_r;
  logic [yrc_pkg::CHAN_W-1:0]        y1_r;

  // Chroma minus its offset, sign extended to the product width.
  assign du = yrc_pkg::PROD_W'($signed({1'b0, in_data.blue_chroma}))
            - yrc_pkg::PROD_W'($signed({1'b0, yrc_pkg::CHROMA_OFFSET}));
  assign dv = yrc_pkg::PROD_W'($signed({1'b0, in_data.red_chroma}))
            - yrc_pkg::PROD_W'($signed({1'b0, yrc_pkg::CHROMA_OFFSET}));

  // Constant multiplications; every product fits the product width.
  always_comb begin
    prod_nxt.rv = dv * yrc_pkg::COEF_RV;
    prod_nxt.gv = dv * yrc_pkg::COEF_GV;
    prod_nxt.gu = du * yrc_pkg::COEF_GU;
    prod_nxt.bu = du * yrc_pkg::COEF_BU;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= prod_nxt;
      y0_r   <= in_data.first_luma;
      y1_r   <= in_data.second_luma;
    end
  end

  assign prod        = prod_r;
  assign first_luma  = y0_r;
  assign second_luma = y1_r;

endmodule

// ===== rtl/yrc_lane.sv =====
// ----------------------------------------------------------------------------
// yrc_lane: one pixel lane
// Combines luma with the chroma products, truncates and clamps each channel, then
// scales it by the output gain with saturation.
// ----------------------------------------------------------------------------
module yrc_lane (
  input  logic                          clk,
  input  yrc_pkg::lane_ctrl_t           ctrl,
  input  logic [yrc_pkg::CHAN_W-1:0]    luma,
  input  yrc_pkg::prod_t                prod,
  input  logic [yrc_pkg::GAIN_W-1:0]    gain,
  output logic [yrc_pkg::CHAN_W-1:0]    red,
  output logic [yrc_pkg::CHAN_W-1:0]    green,
  output logic [yrc_pkg::CHAN_W-1:0]    blue
);

  localparam int HI_W = yrc_pkg::SUM_W - yrc_pkg::FRAC_W;

  logic signed [yrc_pkg::SUM_W-1:0]  yq;
  logic signed [yrc_pkg::SUM_W-1:0]  sum_r;
  logic signed [yrc_pkg::SUM_W-1:0]  sum_g;
  logic signed [yrc_pkg::SUM_W-1:0]  sum_b;
  logic [yrc_pkg::CHAN_W-1:0]        clamp_r_r;
  logic [yrc_pkg::CHAN_W-1:0]        clamp_g_r;
  logic [yrc_pkg::CHAN_W-1:0]        clamp_b_r;
  logic [yrc_pkg::CHAN_W-1:0]        red_r;
  logic [yrc_pkg::CHAN_W-1:0]        green_r;
  logic [yrc_pkg::CHAN_W-1:0]        blue_r;

  // A negative sum truncates to zero or below, so it clamps to zero.
  function automatic logic [yrc_pkg::CHAN_W-1:0] clamp_q16(
    input logic signed [yrc_pkg::SUM_W-1:0] s
  );
    logic [HI_W-1:0] whole;
    logic [yrc_pkg::CHAN_W-1:0] res;
    whole = s[yrc_pkg::SUM_W-1:yrc_pkg::FRAC_W];
    if (s[yrc_pkg::SUM_W-1]) begin
      res = '0;
    end else if (whole > HI_W'(yrc_pkg::CHAN_MAX)) begin
      res = yrc_pkg::CHAN_MAX;
    end else begin
      res = whole[yrc_pkg::CHAN_W-1:0];
    end
    return res;
  endfunction

  // Channel times gain over 256, saturated at full scale.
  function automatic logic [yrc_pkg::CHAN_W-1:0] scale(
    input logic [yrc_pkg::CHAN_W-1:0] chan,
    input logic [yrc_pkg::GAIN_W-1:0] g
  );
    logic [yrc_pkg::SCALE_W-1:0] p;
    logic [yrc_pkg::CHAN_W-1:0]  res;
    p = yrc_pkg::SCALE_W'(chan) * yrc_pkg::SCALE_W'(g);
    if (p[yrc_pkg::SCALE_W-1]) begin
      res = yrc_pkg::CHAN_MAX;
    end else begin
      res = p[yrc_pkg::SCALE_W-2:yrc_pkg::CHAN_W];
    end
    return res;
  endfunction

  // Luma in Q16 combined with the chroma terms of each channel.
  assign yq    = $signed({{(yrc_pkg::SUM_W-yrc_pkg::CHAN_W-yrc_pkg::FRAC_W){1'b0}},
                          luma, {yrc_pkg::FRAC_W{1'b0}}});
  assign sum_r = yq + yrc_pkg::SUM_W'(prod.rv);
  assign sum_g = yq - yrc_pkg::SUM_W'(prod.gv) - yrc_pkg::SUM_W'(prod.gu);
  assign sum_b = yq + yrc_pkg::SUM_W'(prod.bu);

  // Clamp stage.
  always_ff @(posedge clk) begin
    if (ctrl.load_sum) begin
      clamp_r_r <= clamp_q16(sum_r);
      clamp_g_r <= clamp_q16(sum_g);
      clamp_b_r <= clamp_q16(sum_b);
    end
  end

  // Gain stage, which also serves as this lane's share of the output register.
  always_ff @(posedge clk) begin
    if (ctrl.load_scale) begin
      red_r   <= scale(clamp_r_r, gain);
      green_r <= scale(clamp_g_r, gain);
      blue_r  <= scale(clamp_b_r, gain);
    end
  end

  assign red   = red_r;
  assign green = green_r;
  assign blue  = blue_r;

endmodule
